[design/cwac_pkg.sv]
// Shared types and constants for the chinese wall access checker.
package cwac_pkg;

    // Default depth of the per-subject history.
    localparam int SUBJECTS_DEF = 16;

    // Fixed policy sizes.
    localparam int OBJECTS = 16;
    localparam int FIRMS   = 8;
    localparam int CLASSES = 8;

    // One bit per firm, plus one bit for accesses that have no firm.
    localparam int HIST_W      = 9;
    localparam int NO_FIRM_BIT = 8;

    // Field and register widths.
    localparam int OP_W   = 2;
    localparam int SUBJ_W = 4;
    localparam int OBJ_W  = 4;
    localparam int OFM_W  = 64;
    localparam int FCM_W  = 32;
    localparam int CFG_W  = 64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_OBJECT_FIRM = 1'b0;
    localparam logic CFG_FIRM_CLASS  = 1'b1;

    // Controller states.
    typedef enum logic
    {
        ST_IDLE,
        ST_EVAL
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic capture;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic out_blocked;
    } dp_status_t;

endpackage

[design/cwac_ctrl.sv]
// Controller state machine for the chinese wall access checker.
module cwac_ctrl
    import cwac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Select next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!status.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshake and datapath commands
    always_comb
    begin
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_EVAL:
            begin
                cmd.finish = !status.out_blocked;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[design/cwac_datapath.sv]
// Datapath for the chinese wall access checker: config, history memory, check, result.
module cwac_datapath
    import cwac_pkg::*;
#(
    parameter int SUBJECTS = SUBJECTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [OP_W-1:0]   operation,
    input  logic [SUBJ_W-1:0] subject,
    input  logic [OBJ_W-1:0]  object,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              granted
);

    localparam int IDX_W = (SUBJECTS > 1) ? $clog2(SUBJECTS) : 1;
    localparam int EXT_W = 7;

    logic [OFM_W-1:0]    ofm_reg;
    logic [FCM_W-1:0]    fcm_reg;
    logic [OP_W-1:0]     op_reg;
    logic [EXT_W-1:0]    subj_reg;
    logic [OBJ_W-1:0]    obj_reg;
    logic [2*HIST_W-1:0] rdata_reg;
    logic [SUBJECTS-1:0] valid_reg;
    logic [SUBJECTS-1:0] valid_next;
    logic                out_valid_reg;
    logic                granted_reg;

    logic [2*HIST_W-1:0] hist_mem [SUBJECTS];

    logic [EXT_W-1:0]    in_subj_ext;
    logic [IDX_W-1:0]    in_idx;
    logic [IDX_W-1:0]    idx;
    logic                subj_ok;
    logic [3:0]          obj_nib;
    logic                has_firm;
    logic [2:0]          firm;
    logic [3:0]          firm_nib;
    logic                has_class;
    logic [2:0]          cls;
    logic [FIRMS-1:0]    rival;
    logic [HIST_W-1:0]   acc_hist;
    logic [HIST_W-1:0]   rd_hist;
    logic [HIST_W-1:0]   rival_w;
    logic [HIST_W-1:0]   new_bit;
    logic                is_rw;
    logic                ok;
    logic                do_write;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofm_reg <= '0;
            fcm_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_OBJECT_FIRM)
            begin
                ofm_reg <= cfg_data;
            end
            else
            begin
                fcm_reg <= cfg_data[FCM_W-1:0];
            end
        end
    end

    assign in_subj_ext = {{(EXT_W-SUBJ_W){1'b0}}, subject};
    assign in_idx      = in_subj_ext[IDX_W-1:0];
    assign idx         = subj_reg[IDX_W-1:0];
    assign subj_ok     = subj_reg < EXT_W'(SUBJECTS);

    // Capture the request on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            subj_reg <= in_subj_ext;
            obj_reg  <= object;
        end
    end

    // Read history entry on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rdata_reg <= hist_mem[in_idx];
        end
    end

    // Resolve the object's firm and class
    always_comb
    begin
        obj_nib   = ofm_reg[{obj_reg, 2'b00} +: 4];
        has_firm  = ({1'b0, obj_reg} < 5'(OBJECTS)) && obj_nib[3]
                    && ({1'b0, obj_nib[2:0]} < 4'(FIRMS));
        firm      = obj_nib[2:0];
        firm_nib  = fcm_reg[{firm, 2'b00} +: 4];
        has_class = has_firm && firm_nib[3] && ({1'b0, firm_nib[2:0]} < 4'(CLASSES));
        cls       = firm_nib[2:0];
    end

    // Collect the other firms of the same class
    always_comb
    begin
        for (int f = 0; f < FIRMS; f++)
        begin
            rival[f] = has_class && (3'(f) != firm) && fcm_reg[4*f+3]
                       && ({1'b0, fcm_reg[4*f +: 3]} < 4'(CLASSES))
                       && (fcm_reg[4*f +: 3] == cls);
        end
    end

    // Check the history against the rivals
    always_comb
    begin
        acc_hist = valid_reg[idx] ? rdata_reg[HIST_W-1:0] : '0;
        rd_hist  = valid_reg[idx] ? rdata_reg[2*HIST_W-1:HIST_W] : '0;
        rival_w  = {{(HIST_W-FIRMS){1'b0}}, rival};
        new_bit  = '0;
        if (has_firm)
        begin
            new_bit = HIST_W'(1) << firm;
        end
        else
        begin
            new_bit[NO_FIRM_BIT] = 1'b1;
        end
        is_rw = (op_reg == OP_READ) || (op_reg == OP_WRITE);
        ok    = is_rw && subj_ok && ((acc_hist & rival_w) == '0)
                && ((op_reg != OP_WRITE) || ((rd_hist & rival_w) == '0));
        do_write = cmd.finish && ok;
    end

    // Record a granted access
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            hist_mem[idx] <= {(op_reg == OP_READ) ? (rd_hist | new_bit) : rd_hist,
                              acc_hist | new_bit};
        end
    end

    // Mark entries written, drop all on clear
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.finish && (op_reg == OP_CLEAR))
        begin
            valid_next = '0;
        end
        else if (do_write)
        begin
            valid_next[idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            granted_reg <= ok || (op_reg == OP_CLEAR);
        end
    end

    assign status.out_blocked = out_valid_reg && out_stall;
    assign out_valid          = out_valid_reg;
    assign granted            = granted_reg;

endmodule

[design/chinese_wall_access_check.sv]
// Top level of the chinese wall access checker.
//
// Requests (operation, subject, object) come in on the in_valid/in_stall
// channel; a transfer happens when in_valid is high and in_stall is low.
// Each request yields one result, granted, on the out_valid/out_stall channel.
// Read and write requests are checked against the subject's history of firms
// accessed and read; a granted request is recorded. Clear empties all history.
// Configuration (object to firm map, firm to class map) is written through
// cfg_write/cfg_index/cfg_data; the user must write it only while no request is in
// flight, as the block itself does not enforce this.
// A request is taken only in ST_IDLE, so no new one is taken until the last is
// checked: the transfer edge reads the history memory port into rdata_reg, then
// ST_EVAL checks it, writes a granted entry back and sets the registered out_valid.
// When the receiver stalls, the result is held in the output register; the
// block still takes one more request and holds it, with in_stall high, until
// the waiting result is transferred.
// Reset (rst_n low, asynchronous) clears the configuration, all history and
// any pending result.
module chinese_wall_access_check
    import cwac_pkg::*;
#(
    parameter int SUBJECTS = SUBJECTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [SUBJ_W-1:0] subject,
    input  logic [OBJ_W-1:0]  object,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              granted
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    cwac_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cwac_datapath #(
        .SUBJECTS (SUBJECTS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (operation),
        .subject   (subject),
        .object    (object),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .granted   (granted)
    );

endmodule
